[sv/qtt_pkg.sv]
`default_nettype none
package qtt_pkg;

  localparam int OFFSET_BITS   = 24;
  localparam int POSITION_BITS = 16;

  localparam int OFF_W  = OFFSET_BITS;
  localparam int POS_W  = POSITION_BITS;
  localparam int LEN_W  = 16;
  localparam int HEAD_W = 40;
  localparam int HEAD_BYTES = HEAD_W / 8;

  localparam int OP_DEPTH  = 4;
  localparam int OUT_DEPTH = 4;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_MINUS   = 8'h2D;

  localparam logic [HEAD_W-1:0] WORD_AND   = 40'h00_0061_6E64;
  localparam logic [HEAD_W-1:0] WORD_OR    = 40'h00_0000_6F72;
  localparam logic [HEAD_W-1:0] WORD_TRUE  = 40'h00_7472_7565;
  localparam logic [HEAD_W-1:0] WORD_FALSE = 40'h66_616C_7365;

  typedef enum logic [3:0] {
    KIND_LPAREN = 4'd0,
    KIND_RPAREN = 4'd1,
    KIND_NUMBER = 4'd2,
    KIND_IDENT  = 4'd3,
    KIND_AND    = 4'd4,
    KIND_OR     = 4'd5,
    KIND_TRUE   = 4'd6,
    KIND_FALSE  = 4'd7,
    KIND_ERROR  = 4'd8,
    KIND_END    = 4'd9
  } token_kind_t;

  typedef enum logic [2:0] {
    CC_SPACE,
    CC_NEWLINE,
    CC_LPAREN,
    CC_RPAREN,
    CC_DIGIT,
    CC_WORD,
    CC_OTHER
  } char_class_t;

  typedef struct packed {
    logic        is_end;
    char_class_t cls;
    logic [7:0]  char_code;
  } op_t;

  typedef struct packed {
    token_kind_t      token_kind;
    logic [OFF_W-1:0] start_offset;
    logic [LEN_W-1:0] token_length;
    logic [POS_W-1:0] start_line;
    logic [POS_W-1:0] start_column;
    logic [POS_W-1:0] end_line;
    logic [POS_W-1:0] end_column;
    logic             last_in_run;
  } token_rec_t;

  typedef struct packed {
    logic [1:0] count;
    token_rec_t r0;
    token_rec_t r1;
  } emit_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t cls;
    if (c == CH_LF) begin
      cls = CC_NEWLINE;
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
      cls = CC_SPACE;
    end else if (c == CH_LPAREN) begin
      cls = CC_LPAREN;
    end else if (c == CH_RPAREN) begin
      cls = CC_RPAREN;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cls = CC_DIGIT;
    end else if (c == CH_UNDER || c == CH_MINUS || (c >= 8'h61 && c <= 8'h7A) ||
                 (c >= 8'h41 && c <= 8'h5A)) begin
      cls = CC_WORD;
    end else begin
      cls = CC_OTHER;
    end
    return cls;
  endfunction

endpackage
`default_nettype wire

[sv/qtt_if.sv]
`default_nettype none
interface qtt_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_code;

  modport source(output valid, output action, output char_code, input ready);
  modport sink(input valid, input action, input char_code, output ready);
endinterface

interface qtt_out_if;
  logic                      valid;
  logic                      ready;
  logic [3:0]                token_kind;
  logic [qtt_pkg::OFF_W-1:0] start_offset;
  logic [qtt_pkg::LEN_W-1:0] token_length;
  logic [qtt_pkg::POS_W-1:0] start_line;
  logic [qtt_pkg::POS_W-1:0] start_column;
  logic [qtt_pkg::POS_W-1:0] end_line;
  logic [qtt_pkg::POS_W-1:0] end_column;
  logic                      last_in_run;

  modport source(output valid, output token_kind, output start_offset, output token_length,
                 output start_line, output start_column, output end_line,
                 output end_column, output last_in_run, input ready);
  modport sink(input valid, input token_kind, input start_offset, input token_length,
               input start_line, input start_column, input end_line,
               input end_column, input last_in_run, output ready);
endinterface
`default_nettype wire

[sv/qtt_front.sv]
`default_nettype none
module qtt_front (
  input  wire logic         clk,
  input  wire logic         rst,
  qtt_in_if.sink            in_ch,
  output qtt_pkg::op_t      op,
  output logic              op_valid,
  input  wire logic         op_take
);
  import qtt_pkg::*;

  localparam int PTR_W = $clog2(OP_DEPTH);
  localparam int CNT_W = $clog2(OP_DEPTH + 1);

  op_t              mem [OP_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;
  op_t              op_in;

  assign in_ch.ready = (count != CNT_W'(OP_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign op_valid    = (count != '0);
  assign pop         = op_valid && op_take;
  assign op          = mem[rptr];

  always_comb begin
    op_in.is_end    = in_ch.action;
    op_in.cls       = classify(in_ch.char_code);
    op_in.char_code = in_ch.char_code;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= op_in;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

[sv/qtt_back.sv]
`default_nettype none
module qtt_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire qtt_pkg::op_t  op,
  input  wire logic          take,
  output qtt_pkg::emit_t     emit
);
  import qtt_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_WORD,
    MODE_ERROR
  } scan_mode_t;

  scan_mode_t               scan_mode, scan_mode_next;
  logic [OFFSET_BITS-1:0]   text_offset, text_offset_next;
  logic [POSITION_BITS-1:0] line_now, line_now_next;
  logic [POSITION_BITS-1:0] column_now, column_now_next;
  logic [OFFSET_BITS-1:0]   tok_offset, tok_offset_next;
  logic [POSITION_BITS-1:0] tok_line, tok_line_next;
  logic [POSITION_BITS-1:0] tok_column, tok_column_next;
  logic [LEN_W-1:0]         token_bytes, token_bytes_next;
  logic [HEAD_W-1:0]        word_head, word_head_next;

  logic        open_now;
  logic        grow;
  logic        advance;
  logic        go_on;
  logic        flush_v;
  logic        second_v;
  token_rec_t  flush_r;
  token_rec_t  second_r;
  token_kind_t word_kind;
  token_kind_t second_kind;
  logic [LEN_W-1:0]  base_bytes;
  logic [HEAD_W-1:0] base_head;

  always_comb begin
    word_kind = KIND_IDENT;
    if (token_bytes == LEN_W'(3) && word_head == WORD_AND) begin
      word_kind = KIND_AND;
    end else if (token_bytes == LEN_W'(2) && word_head == WORD_OR) begin
      word_kind = KIND_OR;
    end else if (token_bytes == LEN_W'(4) && word_head == WORD_TRUE) begin
      word_kind = KIND_TRUE;
    end else if (token_bytes == LEN_W'(5) && word_head == WORD_FALSE) begin
      word_kind = KIND_FALSE;
    end
  end

  always_comb begin
    flush_r.token_kind   = (scan_mode == MODE_NUMBER) ? KIND_NUMBER : word_kind;
    flush_r.start_offset = OFF_W'(tok_offset);
    flush_r.token_length = token_bytes;
    flush_r.start_line   = POS_W'(tok_line);
    flush_r.start_column = POS_W'(tok_column);
    flush_r.end_line     = POS_W'(line_now);
    flush_r.end_column   = POS_W'(column_now);
    flush_r.last_in_run  = 1'b0;

    second_r.token_kind   = second_kind;
    second_r.start_offset = OFF_W'(text_offset);
    second_r.token_length = (second_kind == KIND_END) ? '0 : LEN_W'(1);
    second_r.start_line   = POS_W'(line_now);
    second_r.start_column = POS_W'(column_now);
    second_r.end_line     = POS_W'(line_now);
    second_r.end_column   = POS_W'(column_now);
    second_r.last_in_run  = 1'b1;
  end

  always_comb begin
    scan_mode_next   = scan_mode;
    tok_offset_next  = tok_offset;
    tok_line_next    = tok_line;
    tok_column_next  = tok_column;
    token_bytes_next = token_bytes;
    word_head_next   = word_head;
    text_offset_next = text_offset;
    line_now_next    = line_now;
    column_now_next  = column_now;
    open_now    = 1'b0;
    grow        = 1'b0;
    advance     = 1'b0;
    flush_v     = 1'b0;
    second_v    = 1'b0;
    second_kind = KIND_END;
    go_on = (scan_mode == MODE_NUMBER && op.cls == CC_DIGIT) ||
            (scan_mode == MODE_WORD && (op.cls == CC_DIGIT || op.cls == CC_WORD));

    if (take) begin
      if (op.is_end) begin
        flush_v  = (scan_mode == MODE_NUMBER) || (scan_mode == MODE_WORD);
        second_v = 1'b1;
      end else if (scan_mode != MODE_ERROR) begin
        if (go_on) begin
          grow    = 1'b1;
          advance = 1'b1;
        end else begin
          flush_v = (scan_mode == MODE_NUMBER) || (scan_mode == MODE_WORD);
          scan_mode_next = MODE_IDLE;
          unique case (op.cls) inside
            CC_SPACE, CC_NEWLINE: begin
              advance = 1'b1;
            end
            CC_LPAREN, CC_RPAREN: begin
              second_v    = 1'b1;
              second_kind = (op.cls == CC_LPAREN) ? KIND_LPAREN : KIND_RPAREN;
              advance     = 1'b1;
            end
            CC_DIGIT, CC_WORD: begin
              scan_mode_next = (op.cls == CC_DIGIT) ? MODE_NUMBER : MODE_WORD;
              open_now = 1'b1;
              grow     = 1'b1;
              advance  = 1'b1;
            end
            default: begin
              second_v       = 1'b1;
              second_kind    = KIND_ERROR;
              scan_mode_next = MODE_ERROR;
            end
          endcase
        end
      end
    end

    if (open_now) begin
      tok_offset_next = text_offset;
      tok_line_next   = line_now;
      tok_column_next = column_now;
    end
    base_bytes = open_now ? '0 : token_bytes;
    base_head  = open_now ? '0 : word_head;
    if (grow) begin
      word_head_next = (base_bytes < LEN_W'(HEAD_BYTES)) ? {base_head[HEAD_W-9:0], op.char_code}
                                                         : base_head;
      token_bytes_next = (base_bytes != '1) ? base_bytes + LEN_W'(1) : base_bytes;
    end
    if (advance) begin
      if (text_offset != '1) begin
        text_offset_next = text_offset + OFFSET_BITS'(1);
      end
      if (op.cls == CC_NEWLINE) begin
        if (line_now != '1) begin
          line_now_next = line_now + POSITION_BITS'(1);
        end
        column_now_next = POSITION_BITS'(1);
      end else if (column_now != '1) begin
        column_now_next = column_now + POSITION_BITS'(1);
      end
    end

    emit.r1 = second_r;
    if (flush_v) begin
      emit.r0 = flush_r;
      emit.r0.last_in_run = !second_v;
      emit.count = second_v ? 2'd2 : 2'd1;
    end else begin
      emit.r0 = second_r;
      emit.count = second_v ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && op.is_end)) begin
      scan_mode   <= MODE_IDLE;
      text_offset <= '0;
      line_now    <= POSITION_BITS'(1);
      column_now  <= POSITION_BITS'(1);
      tok_offset  <= '0;
      tok_line    <= POSITION_BITS'(1);
      tok_column  <= POSITION_BITS'(1);
      token_bytes <= '0;
      word_head   <= '0;
    end else begin
      scan_mode   <= scan_mode_next;
      text_offset <= text_offset_next;
      line_now    <= line_now_next;
      column_now  <= column_now_next;
      tok_offset  <= tok_offset_next;
      tok_line    <= tok_line_next;
      tok_column  <= tok_column_next;
      token_bytes <= token_bytes_next;
      word_head   <= word_head_next;
    end
  end

endmodule
`default_nettype wire

[sv/qtt_out_buf.sv]
`default_nettype none
module qtt_out_buf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire qtt_pkg::emit_t  emit,
  output logic                 room,
  qtt_out_if.source            out_ch
);
  import qtt_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  token_rec_t       mem [OUT_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             pop;
  token_rec_t       head;

  assign room   = (count <= CNT_W'(OUT_DEPTH - 2));
  assign pop    = out_ch.valid && out_ch.ready;
  assign head   = mem[rptr];

  assign out_ch.valid        = (count != '0);
  assign out_ch.token_kind   = head.token_kind;
  assign out_ch.start_offset = head.start_offset;
  assign out_ch.token_length = head.token_length;
  assign out_ch.start_line   = head.start_line;
  assign out_ch.start_column = head.start_column;
  assign out_ch.end_line     = head.end_line;
  assign out_ch.end_column   = head.end_column;
  assign out_ch.last_in_run  = head.last_in_run;

  always_ff @(posedge clk) begin
    if (emit.count != 2'd0) begin
      mem[wptr] <= emit.r0;
    end
    if (emit.count == 2'd2) begin
      mem[wptr + PTR_W'(1)] <= emit.r1;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr <= wptr + PTR_W'(emit.count);
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      count <= count + CNT_W'(emit.count) - CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

[sv/query_text_tokenizer.sv]
`default_nettype none
// Channel   Dir  Payload
// in_ch     in   action, char_code
// out_ch    out  token_kind, start_offset, token_length, start/end line and column,
//                last_in_run
//
// One byte or end-of-text transfer per cycle while the four-entry op queue has space.
// A transfer is stored in the op queue, then the result buffer, before out_ch; the
// scanner takes one queued op per cycle, pausing only while the four-entry result
// buffer has under two free slots. Synchronous rst clears both queues and scan state.
module query_text_tokenizer (
  input  wire logic  clk,
  input  wire logic  rst,
  qtt_in_if.sink     in_ch,
  qtt_out_if.source  out_ch
);
  import qtt_pkg::*;

  op_t   op;
  logic  op_valid;
  logic  room;
  logic  take;
  emit_t emit;

  assign take = op_valid && room;

  qtt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .op       (op),
    .op_valid (op_valid),
    .op_take  (take)
  );

  qtt_back u_back (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .take (take),
    .emit (emit)
  );

  qtt_out_buf u_out_buf (
    .clk    (clk),
    .rst    (rst),
    .emit   (emit),
    .room   (room),
    .out_ch (out_ch)
  );

`ifndef SYNTH
  a_two_results_mark_last: assert property (@(posedge clk) disable iff (rst)
    emit.count == 2'd2 |-> !emit.r0.last_in_run && emit.r1.last_in_run)
    else $error("last_in_run misplaced in a two-token run");

  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    take && op.is_end |->
      (emit.count == 2'd1 && emit.r0.token_kind == KIND_END) ||
      (emit.count == 2'd2 && emit.r1.token_kind == KIND_END))
    else $error("end of text did not close with an end token");

  a_no_emit_without_take: assert property (@(posedge clk) disable iff (rst)
    !take |-> emit.count == 2'd0)
    else $error("tokens emitted without an op");

  a_error_single_byte: assert property (@(posedge clk) disable iff (rst)
    emit.count != 2'd0 && emit.r0.token_kind == KIND_ERROR |->
      emit.r0.token_length == LEN_W'(1) && emit.r0.end_column == emit.r0.start_column)
    else $error("error token shape wrong");
`endif

endmodule
`default_nettype wire
